[sv/phone_lookahead_score_accumulator_top_defines.svh]
// Assertion macros for the phone lookahead score accumulator checker.
`ifndef PHONE_LOOKAHEAD_SCORE_ACCUMULATOR_TOP_DEFINES_SVH
`define PHONE_LOOKAHEAD_SCORE_ACCUMULATOR_TOP_DEFINES_SVH

// check a consequence in the cycle after reset is seen
`define PLSA_ASSERT_AFTER_RESET(label, cons) \
   label: assert property (@(posedge clock) reset |=> (cons)) \
      else $error("reset check failed");

// check a consequence in the cycle after a condition, outside reset
`define PLSA_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("sequence check failed");

`endif

[sv/plsa_pkg.sv]
// Types, constants and arithmetic helpers of the phone lookahead score accumulator.
`timescale 1ns / 1ps
package plsa_pkg;

   localparam int SCORE_W = 32;
   localparam int PHONE_W = 6;
   localparam int FUNC_W = 2;
   localparam int MODE_W = 2;
   localparam int COUNT_W = 4;
   localparam int CSR_INDEX_W = 2;
   localparam int CSR_DATA_W = 4;

   localparam int PLSA_PHONES = 64;
   localparam int PLSA_QUEUE_DEPTH = 2;

   localparam logic [SCORE_W-1:0] MOST_NEG = 32'h8000_0000;

   localparam logic [FUNC_W-1:0] FUNC_CLEAR = 2'd0;
   localparam logic [FUNC_W-1:0] FUNC_SCORE = 2'd1;
   localparam logic [FUNC_W-1:0] FUNC_READ = 2'd2;

   localparam logic [MODE_W-1:0] MODE_OFF = 2'd0;
   localparam logic [MODE_W-1:0] MODE_MAX = 2'd1;
   localparam logic [MODE_W-1:0] MODE_AVG = 2'd2;
   localparam logic [MODE_W-1:0] MODE_FIRST = 2'd3;

   localparam logic [MODE_W-1:0] RESET_MODE = MODE_MAX;
   localparam logic [COUNT_W-1:0] RESET_COUNT = 4'd3;

   localparam logic [CSR_INDEX_W-1:0] CSR_REDUCE_MODE = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_STATE_COUNT = 2'd1;

   typedef enum logic [1:0] {
      OP_CLEAR = 2'd0,
      OP_SCORE = 2'd1,
      OP_READ = 2'd2
   } plsa_op_type;

   typedef struct packed {
      logic [FUNC_W-1:0] func;
      logic signed [SCORE_W-1:0] senone_score;
      logic [PHONE_W-1:0] phone_index;
      logic phone_start;
      logic phone_last;
   } plsa_req_type;

   typedef struct packed {
      logic [PHONE_W-1:0] out_phone;
      logic signed [SCORE_W-1:0] heuristic;
   } plsa_rsp_type;

   typedef struct packed {
      plsa_op_type op;
      logic [SCORE_W-1:0] score;
      logic [PHONE_W-1:0] phone;
      logic phone_start;
      logic phone_last;
      logic in_range;
   } plsa_cmd_type;

   typedef struct packed {
      logic [MODE_W-1:0] reduce_mode;
      logic [COUNT_W-1:0] state_count;
   } plsa_cfg_type;

   function automatic logic [SCORE_W-1:0] sat_add(input logic [SCORE_W-1:0] a,
                                                   input logic [SCORE_W-1:0] b);
      logic [SCORE_W-1:0] c;
      c = a + b;
      if (a[SCORE_W-1] && b[SCORE_W-1] && (c != '0) && !c[SCORE_W-1]) begin
         return MOST_NEG;
      end
      return c;
   endfunction

   function automatic logic [SCORE_W-1:0] smax(input logic [SCORE_W-1:0] a,
                                                input logic [SCORE_W-1:0] b);
      return ($signed(a) < $signed(b)) ? b : a;
   endfunction

endpackage

[sv/plsa_queue.sv]
// Small register queue used for commands and for results.
`timescale 1ns / 1ps
module plsa_queue import plsa_pkg::*; #(
   parameter int WIDTH = 8,
   parameter int DEPTH = PLSA_QUEUE_DEPTH
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] push_data,
   output logic             full,
   input  logic             pop,
   output logic             empty,
   output logic [WIDTH-1:0] head_data
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] data_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic do_push, do_pop;

   assign full = (count_ff == CNT_W'(DEPTH));
   assign empty = (count_ff == '0);
   assign head_data = data_ff[rd_ptr_ff];
   assign do_push = push && !full;
   assign do_pop = pop && !empty;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         data_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

[sv/plsa_front.sv]
// Front end: classify incoming items into commands and drop those with no effect.
`timescale 1ns / 1ps
module plsa_front import plsa_pkg::*; #(
   parameter int PHONES = PLSA_PHONES
) (
   input  plsa_cfg_type cfg,
   input  logic         req_push,
   input  plsa_req_type req_data,
   input  logic         cmd_full,
   output logic         cmd_push,
   output plsa_cmd_type cmd_data
);

   localparam int DEPTH = (PHONES < (1 << PHONE_W)) ? PHONES : (1 << PHONE_W);

   logic keep;

   always_comb begin
      keep = 1'b0;
      cmd_data.op = OP_CLEAR;
      unique case (req_data.func)
         FUNC_CLEAR: begin
            keep = 1'b1;
            cmd_data.op = OP_CLEAR;
         end
         FUNC_READ: begin
            keep = 1'b1;
            cmd_data.op = OP_READ;
         end
         FUNC_SCORE: begin
            keep = (cfg.reduce_mode != MODE_OFF);
            cmd_data.op = OP_SCORE;
         end
         default: begin
            keep = 1'b0;
         end
      endcase
      cmd_data.score = req_data.senone_score;
      cmd_data.phone = req_data.phone_index;
      cmd_data.phone_start = req_data.phone_start;
      cmd_data.phone_last = req_data.phone_last;
      cmd_data.in_range = ({1'b0, req_data.phone_index} < (PHONE_W + 1)'(DEPTH));
   end

   assign cmd_push = req_push && !cmd_full && keep;

endmodule

[sv/plsa_div.sv]
// Bit-serial signed-by-unsigned divider, truncating toward zero.
`timescale 1ns / 1ps
module plsa_div import plsa_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   input  logic [SCORE_W-1:0] dividend,
   input  logic [COUNT_W-1:0] divisor,
   output logic               done,
   output logic [SCORE_W-1:0] quotient
);

   localparam int STEP_W = $clog2(SCORE_W);

   logic busy_ff, busy_in;
   logic done_ff, done_in;
   logic [STEP_W-1:0] step_ff, step_in;
   logic [COUNT_W-1:0] rem_ff, rem_in;
   logic [SCORE_W-1:0] quo_ff, quo_in;
   logic [COUNT_W-1:0] dsr_ff, dsr_in;
   logic neg_ff, neg_in;
   logic [COUNT_W:0] trial;

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      step_in = step_ff;
      rem_in = rem_ff;
      quo_in = quo_ff;
      dsr_in = dsr_ff;
      neg_in = neg_ff;
      trial = {rem_ff, quo_ff[SCORE_W-1]};
      if (start) begin
         busy_in = 1'b1;
         step_in = '0;
         rem_in = '0;
         neg_in = dividend[SCORE_W-1];
         quo_in = dividend[SCORE_W-1] ? (~dividend + 1'b1) : dividend;
         dsr_in = (divisor == '0) ? COUNT_W'(1) : divisor;
      end else if (busy_ff) begin
         if (trial >= {1'b0, dsr_ff}) begin
            rem_in = COUNT_W'(trial - {1'b0, dsr_ff});
            quo_in = {quo_ff[SCORE_W-2:0], 1'b1};
         end else begin
            rem_in = COUNT_W'(trial);
            quo_in = {quo_ff[SCORE_W-2:0], 1'b0};
         end
         step_in = step_ff + 1'b1;
         if (step_ff == STEP_W'(SCORE_W - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         step_ff <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         step_ff <= step_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      dsr_ff <= dsr_in;
      neg_ff <= neg_in;
   end

   assign done = done_ff;
   assign quotient = neg_ff ? (~quo_ff + 1'b1) : quo_ff;

endmodule

[sv/plsa_back.sv]
// Back end: phone table, running reduction and result generation.
`timescale 1ns / 1ps
module plsa_back import plsa_pkg::*; #(
   parameter int PHONES = PLSA_PHONES
) (
   input  logic         clock,
   input  logic         reset,
   input  plsa_cfg_type cfg,
   input  logic         cmd_empty,
   input  plsa_cmd_type cmd_head,
   output logic         cmd_pop,
   input  logic         rsp_full,
   output logic         rsp_push,
   output plsa_rsp_type rsp_data
);

   localparam int DEPTH = (PHONES < (1 << PHONE_W)) ? PHONES : (1 << PHONE_W);
   localparam int IDX_W = $clog2(DEPTH);

   typedef enum logic [4:0] {
      ST_IDLE = 5'b00001,
      ST_LOAD = 5'b00010,
      ST_DIV = 5'b00100,
      ST_FINISH = 5'b01000,
      ST_READ = 5'b10000
   } state_type;

   state_type state_ff, state_in;
   plsa_cmd_type cmd_ff, cmd_in;
   logic [SCORE_W-1:0] running_ff, running_in;
   logic [SCORE_W-1:0] base_ff, base_in;
   logic [SCORE_W-1:0] red_ff, red_in;
   logic [SCORE_W-1:0] table_mem [DEPTH];
   logic [SCORE_W-1:0] rd_data_ff;
   logic rd_valid_ff;
   logic [DEPTH-1:0] valid_ff;
   logic mem_rd, mem_wr, clear_all, div_start, div_done;
   logic [SCORE_W-1:0] wr_val, div_quo;
   logic [SCORE_W-1:0] run_base, run_next, entry, first_sum, total;
   logic [IDX_W-1:0] rd_addr, wr_addr;

   assign rd_addr = cmd_head.phone[IDX_W-1:0];
   assign wr_addr = cmd_ff.phone[IDX_W-1:0];
   assign entry = rd_valid_ff ? rd_data_ff : '0;
   assign first_sum = sat_add(entry, cmd_ff.score);
   assign total = sat_add(base_ff, red_ff);

   always_comb begin
      if (cmd_head.phone_start) begin
         run_base = (cfg.reduce_mode == MODE_AVG) ? '0 : MOST_NEG;
      end else begin
         run_base = running_ff;
      end
      if (cfg.reduce_mode == MODE_AVG) begin
         run_next = sat_add(cmd_head.score, run_base);
      end else begin
         run_next = smax(run_base, cmd_head.score);
      end
   end

   always_comb begin
      state_in = state_ff;
      cmd_in = cmd_ff;
      running_in = running_ff;
      base_in = base_ff;
      red_in = red_ff;
      mem_rd = 1'b0;
      mem_wr = 1'b0;
      wr_val = first_sum;
      clear_all = 1'b0;
      div_start = 1'b0;
      cmd_pop = 1'b0;
      rsp_push = 1'b0;
      rsp_data.out_phone = cmd_ff.phone;
      rsp_data.heuristic = entry;
      unique case (state_ff)
         ST_IDLE: begin
            if (!cmd_empty && !rsp_full) begin
               cmd_pop = 1'b1;
               cmd_in = cmd_head;
               unique case (cmd_head.op)
                  OP_CLEAR: begin
                     clear_all = 1'b1;
                     running_in = MOST_NEG;
                  end
                  OP_READ: begin
                     mem_rd = 1'b1;
                     state_in = ST_READ;
                  end
                  OP_SCORE: begin
                     running_in = run_next;
                     if (cmd_head.phone_last) begin
                        red_in = run_next;
                        running_in = MOST_NEG;
                     end
                     if (cmd_head.phone_last ||
                         ((cfg.reduce_mode == MODE_FIRST) && cmd_head.phone_start)) begin
                        mem_rd = 1'b1;
                        state_in = ST_LOAD;
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end
         ST_READ: begin
            rsp_push = 1'b1;
            state_in = ST_IDLE;
         end
         ST_LOAD: begin
            base_in = entry;
            if ((cfg.reduce_mode == MODE_FIRST) && cmd_ff.phone_start && cmd_ff.in_range) begin
               base_in = first_sum;
               mem_wr = 1'b1;
               wr_val = first_sum;
            end
            if (!cmd_ff.phone_last) begin
               state_in = ST_IDLE;
            end else if (cfg.reduce_mode == MODE_AVG) begin
               div_start = 1'b1;
               state_in = ST_DIV;
            end else begin
               state_in = ST_FINISH;
            end
         end
         ST_DIV: begin
            if (div_done) begin
               red_in = div_quo;
               state_in = ST_FINISH;
            end
         end
         ST_FINISH: begin
            mem_wr = cmd_ff.in_range;
            wr_val = total;
            rsp_push = 1'b1;
            rsp_data.heuristic = cmd_ff.in_range ? total : '0;
            state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   plsa_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (red_ff),
      .divisor  (cfg.state_count),
      .done     (div_done),
      .quotient (div_quo)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         running_ff <= MOST_NEG;
         valid_ff <= '0;
      end else begin
         state_ff <= state_in;
         running_ff <= running_in;
         if (clear_all) begin
            valid_ff <= '0;
         end else if (mem_wr) begin
            valid_ff[wr_addr] <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff <= cmd_in;
      base_ff <= base_in;
      red_ff <= red_in;
      if (mem_rd) begin
         rd_data_ff <= table_mem[rd_addr];
         rd_valid_ff <= valid_ff[rd_addr] && cmd_head.in_range;
      end
      if (mem_wr) begin
         table_mem[wr_addr] <= wr_val;
      end
   end

endmodule

[sv/phone_lookahead_score_accumulator_top.sv]
// Top level of the phone lookahead score accumulator.
//
// Input queue: drive req_data and raise req_push; a transfer happens at a
// clock edge with req_push high and req_full low. Results come out of a
// queue: while rsp_empty is low, rsp_data holds the oldest result, taken at
// an edge with rsp_pop high. The csr_ port writes reduce_mode (index 0) and
// state_count (index 1); csr_ready is always high. Write it only when idle.
// Items enter a command queue and are carried out one at a time by the table
// sequencer: a clear or a score item that touches no entry ends in idle, a
// read passes the read state, a first score in mode 3 the load state, and a
// phone end the load and finish states in modes 1 and 3 and in mode 2 also a
// 32-step bit-serial divider. Results are queued by the read or finish state.
// Reset empties both queues, clears all table valid bits, sets the running
// value to the most negative number and the registers to mode 1, count 3.
// When the result queue is full the sequencer holds; items keep entering
// the command queue until it fills and req_full rises.
`timescale 1ns / 1ps
module phone_lookahead_score_accumulator_top import plsa_pkg::*; #(
   parameter int PHONES = PLSA_PHONES,
   parameter int QUEUE_DEPTH = PLSA_QUEUE_DEPTH
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_push,
   output logic                   req_full,
   input  plsa_req_type           req_data,
   output logic                   rsp_empty,
   input  logic                   rsp_pop,
   output plsa_rsp_type           rsp_data,
   input  logic                   csr_valid,
   output logic                   csr_ready,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_data
);

   localparam int CMD_W = $bits(plsa_cmd_type);
   localparam int RSP_W = $bits(plsa_rsp_type);

   plsa_cfg_type cfg_ff, cfg_in;
   logic cmd_push, cmd_full, cmd_pop, cmd_empty;
   plsa_cmd_type cmd_data, cmd_head;
   logic [CMD_W-1:0] cmd_head_bits;
   logic rsp_push, rsp_full;
   plsa_rsp_type rsp_in;
   logic [RSP_W-1:0] rsp_head_bits;

   assign csr_ready = 1'b1;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid && csr_ready) begin
         unique case (csr_index)
            CSR_REDUCE_MODE: cfg_in.reduce_mode = csr_data[MODE_W-1:0];
            CSR_STATE_COUNT: cfg_in.state_count = csr_data[COUNT_W-1:0];
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.reduce_mode <= RESET_MODE;
         cfg_ff.state_count <= RESET_COUNT;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   plsa_front #(
      .PHONES (PHONES)
   ) u_front (
      .cfg      (cfg_ff),
      .req_push (req_push),
      .req_data (req_data),
      .cmd_full (cmd_full),
      .cmd_push (cmd_push),
      .cmd_data (cmd_data)
   );

   assign req_full = cmd_full;

   plsa_queue #(
      .WIDTH (CMD_W),
      .DEPTH (QUEUE_DEPTH)
   ) u_cmd_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (cmd_push),
      .push_data (cmd_data),
      .full      (cmd_full),
      .pop       (cmd_pop),
      .empty     (cmd_empty),
      .head_data (cmd_head_bits)
   );

   assign cmd_head = plsa_cmd_type'(cmd_head_bits);

   plsa_back #(
      .PHONES (PHONES)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg_ff),
      .cmd_empty (cmd_empty),
      .cmd_head  (cmd_head),
      .cmd_pop   (cmd_pop),
      .rsp_full  (rsp_full),
      .rsp_push  (rsp_push),
      .rsp_data  (rsp_in)
   );

   plsa_queue #(
      .WIDTH (RSP_W),
      .DEPTH (QUEUE_DEPTH)
   ) u_rsp_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (rsp_push),
      .push_data (rsp_in),
      .full      (rsp_full),
      .pop       (rsp_pop),
      .empty     (rsp_empty),
      .head_data (rsp_head_bits)
   );

   assign rsp_data = plsa_rsp_type'(rsp_head_bits);

endmodule

[sv/plsa_checker.sv]
// Port-level checker of the phone lookahead score accumulator and its bind.
`timescale 1ns / 1ps
`include "phone_lookahead_score_accumulator_top_defines.svh"
module plsa_checker import plsa_pkg::*; (
   input logic         clock,
   input logic         reset,
   input logic         req_push,
   input logic         req_full,
   input logic         rsp_empty,
   input logic         rsp_pop,
   input plsa_rsp_type rsp_data
);

   `PLSA_ASSERT_AFTER_RESET(a_reset_rsp_empty, rsp_empty)
   `PLSA_ASSERT_AFTER_RESET(a_reset_req_open, !req_full)
   `PLSA_ASSERT_NEXT(a_no_push_stays_open, !req_full && !req_push, !req_full)
   `PLSA_ASSERT_NEXT(a_rsp_held, !rsp_empty && !rsp_pop, !rsp_empty && $stable(rsp_data))

endmodule

bind phone_lookahead_score_accumulator_top plsa_checker u_plsa_checker (
   .clock     (clock),
   .reset     (reset),
   .req_push  (req_push),
   .req_full  (req_full),
   .rsp_empty (rsp_empty),
   .rsp_pop   (rsp_pop),
   .rsp_data  (rsp_data)
);

[tb/sv/phone_lookahead_score_accumulator_top_tb.sv]
// Self-checking testbench for the phone lookahead score accumulator top level.
`timescale 1ns / 1ps
module phone_lookahead_score_accumulator_top_tb;
   import plsa_pkg::*;

   localparam logic [FUNC_W-1:0] FUNC_SPARE = 2'd3;
   localparam logic [CSR_INDEX_W-1:0] CSR_SPARE = 2'd2;
   localparam int NUM_PHASES = 10;
   localparam int DRAIN_CYCLES = 120;
   localparam int HOLD_CYCLES = 400;
   localparam int HOLD_AFTER_POPS = 150;
   localparam int CYCLE_LIMIT = 1000000;

   class heuristic_tracker;
      logic [SCORE_W-1:0] phone_sum [PLSA_PHONES];
      bit phone_live [PLSA_PHONES];
      logic [SCORE_W-1:0] group_value;
      logic [MODE_W-1:0] mode;
      logic [COUNT_W-1:0] divisor;
      plsa_rsp_type expected_heuristics [$];
      int unsigned func_seen [4];
      int unsigned checked;
      int unsigned mismatches;

      function new();
         foreach (phone_live[i]) phone_live[i] = 1'b0;
         foreach (func_seen[i]) func_seen[i] = 0;
         group_value = MOST_NEG;
         mode = RESET_MODE;
         divisor = RESET_COUNT;
         checked = 0;
         mismatches = 0;
      endfunction

      function void configure(logic [CSR_INDEX_W-1:0] index, logic [CSR_DATA_W-1:0] data);
         if (index == CSR_REDUCE_MODE) mode = data[MODE_W-1:0];
         else if (index == CSR_STATE_COUNT) divisor = data[COUNT_W-1:0];
      endfunction

      function logic [SCORE_W-1:0] floor_add(logic [SCORE_W-1:0] a, logic [SCORE_W-1:0] b);
         logic [SCORE_W-1:0] s;
         s = a + b;
         if (a[SCORE_W-1] && b[SCORE_W-1] && !s[SCORE_W-1] && s != '0) s = MOST_NEG;
         return s;
      endfunction

      function logic [SCORE_W-1:0] quotient(logic [SCORE_W-1:0] x);
         int d;
         int q;
         d = (divisor == '0) ? 1 : int'(divisor);
         q = $signed(x) / d;
         return q;
      endfunction

      function logic [SCORE_W-1:0] entry_of(logic [PHONE_W-1:0] p);
         return phone_live[p] ? phone_sum[p] : '0;
      endfunction

      function void store(logic [PHONE_W-1:0] p, logic [SCORE_W-1:0] v);
         phone_sum[p] = v;
         phone_live[p] = 1'b1;
      endfunction

      function void expect_entry(logic [PHONE_W-1:0] p);
         plsa_rsp_type r;
         r.out_phone = p;
         r.heuristic = entry_of(p);
         expected_heuristics.push_back(r);
      endfunction

      function void absorb_item(plsa_req_type item);
         logic [SCORE_W-1:0] v;
         logic [PHONE_W-1:0] p;
         p = item.phone_index;
         func_seen[item.func]++;
         case (item.func)
            FUNC_CLEAR: begin
               foreach (phone_live[i]) phone_live[i] = 1'b0;
               group_value = MOST_NEG;
            end
            FUNC_READ: begin
               expect_entry(p);
            end
            FUNC_SCORE: begin
               if (mode == MODE_OFF) return;
               if (item.phone_start) group_value = (mode == MODE_AVG) ? '0 : MOST_NEG;
               if (mode == MODE_AVG) begin
                  group_value = floor_add(item.senone_score, group_value);
               end else begin
                  if (mode == MODE_FIRST && item.phone_start)
                     store(p, floor_add(entry_of(p), item.senone_score));
                  if ($signed(group_value) < item.senone_score) group_value = item.senone_score;
               end
               if (item.phone_last) begin
                  v = group_value;
                  if (mode == MODE_AVG) v = quotient(v);
                  store(p, floor_add(entry_of(p), v));
                  group_value = MOST_NEG;
                  expect_entry(p);
               end
            end
            default: return;
         endcase
      endfunction

      function void compare_heuristic(plsa_rsp_type got);
         plsa_rsp_type want;
         checked++;
         if (expected_heuristics.size() == 0) begin
            mismatches++;
            $display("%0t: result with nothing expected: expected none, %s %0d heuristic %0d",
                     $time, "actual phone", got.out_phone, got.heuristic);
            return;
         end
         want = expected_heuristics.pop_front();
         if (got.out_phone !== want.out_phone) begin
            mismatches++;
            $display("%0t: out_phone mismatch: expected %0d, actual %0d",
                     $time, want.out_phone, got.out_phone);
         end
         if (got.heuristic !== want.heuristic) begin
            mismatches++;
            $display("%0t: heuristic mismatch on phone %0d: expected %0d, actual %0d",
                     $time, want.out_phone, want.heuristic, got.heuristic);
         end
      endfunction

      function int pending();
         return expected_heuristics.size();
      endfunction
   endclass

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_push = 1'b0;
   logic req_full;
   plsa_req_type req_data = '0;
   logic rsp_empty;
   logic rsp_pop = 1'b0;
   plsa_rsp_type rsp_data;
   logic csr_valid = 1'b0;
   logic csr_ready;
   logic [CSR_INDEX_W-1:0] csr_index = '0;
   logic [CSR_DATA_W-1:0] csr_data = '0;

   heuristic_tracker book;
   int unsigned sent_items = 0;
   int burst_left = 0;
   int unsigned cycles = 0;

   logic [MODE_W-1:0] phase_mode [NUM_PHASES] = '{MODE_MAX, MODE_AVG, MODE_FIRST, MODE_AVG,
      MODE_OFF, MODE_AVG, MODE_FIRST, MODE_AVG, MODE_MAX, MODE_AVG};
   logic [COUNT_W-1:0] phase_count [NUM_PHASES] = '{4'd3, 4'd8, 4'd1, 4'd0, 4'd5, 4'd15,
      4'd8, 4'd1, 4'd8, 4'd3};
   int phase_items [NUM_PHASES] = '{250, 250, 250, 150, 60, 150, 250, 200, 200, 150};

   phone_lookahead_score_accumulator_top u_dut (
      .clock     (clock),
      .reset     (reset),
      .req_push  (req_push),
      .req_full  (req_full),
      .req_data  (req_data),
      .rsp_empty (rsp_empty),
      .rsp_pop   (rsp_pop),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data)
   );

   initial begin
      forever #4 clock = ~clock;
   end

   function automatic plsa_req_type make_item(logic [FUNC_W-1:0] func,
                                              logic [SCORE_W-1:0] score,
                                              logic [PHONE_W-1:0] phone,
                                              bit is_first, bit is_last);
      plsa_req_type item;
      item.func = func;
      item.senone_score = score;
      item.phone_index = phone;
      item.phone_start = is_first;
      item.phone_last = is_last;
      return item;
   endfunction

   function automatic logic [SCORE_W-1:0] pick_score();
      case ($urandom_range(0, 6))
         0: return $urandom;
         1: return MOST_NEG + $urandom_range(0, 32'hf_ffff);
         2: return 32'h7fff_ffff - $urandom_range(0, 32'hf_ffff);
         3: return -$urandom_range(0, 200000);
         4: return $urandom_range(0, 5000);
         5: return -$urandom_range(1900000000, 2147483647);
         default: return -$urandom_range(0, 50);
      endcase
   endfunction

   function automatic logic [PHONE_W-1:0] pick_phone();
      return ($urandom_range(0, 3) == 0) ? PHONE_W'($urandom_range(0, 63)) :
                                           PHONE_W'($urandom_range(0, 7));
   endfunction

   function automatic bit pick_flag();
      return 1'($urandom_range(0, 1));
   endfunction

   // hold each item until its transfer, with bursts and gaps in between
   task automatic offer(input plsa_req_type item);
      int gap;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 24);
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
         if (gap > 0) begin
            req_push <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
      burst_left--;
      req_push <= 1'b1;
      req_data <= item;
      do @(posedge clock); while (req_full);
      book.absorb_item(item);
      sent_items++;
   endtask

   task automatic csr_transfer(input logic [CSR_INDEX_W-1:0] index,
                               input logic [CSR_DATA_W-1:0] data);
      csr_valid <= 1'b1;
      csr_index <= index;
      csr_data <= data;
      do @(posedge clock); while (!csr_ready);
      book.configure(index, data);
   endtask

   task automatic write_settings(input logic [MODE_W-1:0] mode,
                                 input logic [COUNT_W-1:0] count, input bit touch_spare);
      csr_transfer(CSR_REDUCE_MODE, CSR_DATA_W'(mode));
      csr_transfer(CSR_STATE_COUNT, CSR_DATA_W'(count));
      if (touch_spare) csr_transfer(CSR_SPARE, 4'hf);
      csr_valid <= 1'b0;
   endtask

   // drop push and wait out every result and any work still in flight
   task automatic settle();
      req_push <= 1'b0;
      burst_left = 0;
      while (book.pending() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic random_step();
      int pick;
      int len;
      logic [PHONE_W-1:0] p;
      pick = $urandom_range(0, 99);
      p = pick_phone();
      if (pick < 78) begin
         len = $urandom_range(1, 4);
         for (int k = 0; k < len; k++)
            offer(make_item(FUNC_SCORE, pick_score(), p, k == 0, k == len - 1));
      end else if (pick < 86) begin
         offer(make_item(FUNC_READ, pick_score(), p, pick_flag(), pick_flag()));
      end else if (pick < 88) begin
         offer(make_item(FUNC_CLEAR, pick_score(), p, pick_flag(), pick_flag()));
      end else if (pick < 91) begin
         offer(make_item(FUNC_SPARE, pick_score(), p, pick_flag(), pick_flag()));
      end else begin
         offer(make_item(FUNC_SCORE, pick_score(), p, pick_flag(), pick_flag()));
      end
   endtask

   initial begin : result_drain
      int style;
      int style_left;
      int pops_seen;
      bit held;
      style = 0;
      style_left = 0;
      pops_seen = 0;
      held = 1'b0;
      while (reset) @(posedge clock);
      forever begin
         @(posedge clock);
         if (rsp_pop && !rsp_empty) begin
            book.compare_heuristic(rsp_data);
            pops_seen++;
         end
         if (!held && pops_seen >= HOLD_AFTER_POPS) begin
            held = 1'b1;
            rsp_pop <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
         end else begin
            if (style_left == 0) begin
               style = $urandom_range(0, 2);
               style_left = $urandom_range(32, 200);
            end
            style_left--;
            case (style)
               0: rsp_pop <= 1'b1;
               1: rsp_pop <= 1'($urandom_range(0, 1));
               default: rsp_pop <= ($urandom_range(0, 9) == 0);
            endcase
         end
      end
   end

   initial begin : watchdog
      while (cycles < CYCLE_LIMIT) begin
         @(posedge clock);
         cycles++;
      end
      $display("Some tests failed");
      $finish;
   end

   initial begin : stimulus
      int target;
      book = new();
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      offer(make_item(FUNC_CLEAR, 32'h0, 6'd0, 1'b0, 1'b0));
      offer(make_item(FUNC_READ, 32'hffff_ffff, 6'd0, 1'b1, 1'b1));
      offer(make_item(FUNC_READ, 32'h0, 6'd63, 1'b0, 1'b0));
      offer(make_item(FUNC_SCORE, 32'h7fff_ffff, 6'd0, 1'b1, 1'b0));
      offer(make_item(FUNC_SCORE, MOST_NEG, 6'd0, 1'b0, 1'b1));
      offer(make_item(FUNC_SCORE, 32'd1, 6'd0, 1'b1, 1'b1));
      offer(make_item(FUNC_SCORE, MOST_NEG, 6'd63, 1'b1, 1'b1));
      offer(make_item(FUNC_SCORE, MOST_NEG, 6'd63, 1'b1, 1'b1));
      offer(make_item(FUNC_SCORE, -32'sd2000000000, 6'd5, 1'b1, 1'b1));
      offer(make_item(FUNC_SCORE, -32'sd2000000000, 6'd5, 1'b1, 1'b1));
      offer(make_item(FUNC_SCORE, 32'd7, 6'd5, 1'b0, 1'b1));
      offer(make_item(FUNC_SPARE, 32'hffff_ffff, 6'd5, 1'b1, 1'b1));
      offer(make_item(FUNC_SCORE, 32'd100, 6'd9, 1'b1, 1'b0));
      offer(make_item(FUNC_SCORE, -32'sd5, 6'd9, 1'b0, 1'b0));
      offer(make_item(FUNC_CLEAR, 32'hffff_ffff, 6'd63, 1'b1, 1'b1));
      offer(make_item(FUNC_SCORE, -32'sd7, 6'd9, 1'b0, 1'b1));
      offer(make_item(FUNC_READ, 32'h0, 6'd5, 1'b0, 1'b0));
      offer(make_item(FUNC_READ, 32'h0, 6'd63, 1'b0, 1'b0));
      offer(make_item(FUNC_READ, 32'h0, 6'd0, 1'b0, 1'b0));
      offer(make_item(FUNC_SCORE, 32'h1234_5678, 6'd42, 1'b1, 1'b1));
      offer(make_item(FUNC_SCORE, 32'hffff_ffff, 6'd42, 1'b1, 1'b1));
      offer(make_item(FUNC_CLEAR, 32'h0, 6'd0, 1'b0, 1'b0));
      offer(make_item(FUNC_READ, 32'h0, 6'd42, 1'b0, 1'b0));

      for (int ph = 0; ph < NUM_PHASES; ph++) begin
         if (ph > 0) begin
            settle();
            write_settings(phase_mode[ph], phase_count[ph], ph == 8);
         end
         target = sent_items + phase_items[ph];
         while (sent_items < target) random_step();
      end

      settle();
      $display("Covered %0d clears, %0d score items, %0d reads, %0d unused codes",
               book.func_seen[FUNC_CLEAR], book.func_seen[FUNC_SCORE],
               book.func_seen[FUNC_READ], book.func_seen[FUNC_SPARE]);
      $display("over %0d settings; checked %0d results, %0d field errors.",
               NUM_PHASES, book.checked, book.mismatches);
      if (book.mismatches == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

endmodule
